@@ rtl/raster_random_cell_sampler_unit_assert.svh @@
// Assertion macros for the raster random cell sampler unit.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef RASTER_RANDOM_CELL_SAMPLER_UNIT_ASSERT_SVH
`define RASTER_RANDOM_CELL_SAMPLER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define RRCS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rrcs assertion failed");
`define RRCS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rrcs assertion failed");
`else
`define RRCS_ASSERT(lbl, prop)
`define RRCS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/rrcs_pkg.sv @@
// Shared types and constants of the raster random cell sampler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rrcs_pkg;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned OPOS_W      = 16;
  localparam int unsigned RLEN_W      = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned RND_W       = 32;
  localparam int unsigned STEP_W      = $clog2(RND_W);
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NULL_PICK_EN = 3'd0,
    REG_TOTAL_CELLS  = 3'd1,
    REG_NULL_CELLS   = 3'd2,
    REG_SAMPLE_COUNT = 3'd3,
    REG_NULL_FILL    = 3'd4,
    REG_ROW_LENGTH   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic                null_pick_en;
    logic [WORD_W-1:0]   total_cells;
    logic [WORD_W-1:0]   null_cells;
    logic [WORD_W-1:0]   sample_count;
    logic [VALUE_W-1:0]  null_fill_value;
    logic [RLEN_W-1:0]   row_length;
  } cfg_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_null;
    logic               eligible;
    logic [RND_W-1:0]   rnd;
    logic               first;
    logic [OPOS_W-1:0]  row;
    logic [OPOS_W-1:0]  col;
  } cell_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_null;
    logic               selected;
    logic [OPOS_W-1:0]  row;
    logic [OPOS_W-1:0]  col;
    logic [WORD_W-1:0]  picks;
    logic               shortfall;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

@@ rtl/rrcs_front.sv @@
// Front end: accepts cells, tracks row/column position, marks eligibility.
// Depends on rrcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrcs_front #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [rrcs_pkg::VALUE_W-1:0]     cell_value_i,
  input  wire                              cell_is_null_i,
  input  wire  [rrcs_pkg::RND_W-1:0]       random_word_i,
  input  wire                              first_cell_i,
  input  wire                              null_pick_en_i,
  input  wire  [rrcs_pkg::RLEN_W-1:0]      row_length_i,
  input  rrcs_pkg::q_stat_t                q_stat_i,
  output logic                             push_o,
  output rrcs_pkg::cell_t                  push_data_o
);
  import rrcs_pkg::*;

  localparam int unsigned CMP_W = (POS_WIDTH > RLEN_W) ? POS_WIDTH : RLEN_W;

  logic [POS_WIDTH-1:0] row_q, row_d, col_q, col_d;
  logic [POS_WIDTH-1:0] cur_row, cur_col, nxt_col;
  logic [CMP_W-1:0]     nxt_ext, len_ext;
  logic [WORD_W-1:0]    row_wide, col_wide;
  logic                 wrap;

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  assign cur_row = first_cell_i ? '0 : row_q;
  assign cur_col = first_cell_i ? '0 : col_q;
  assign nxt_col = cur_col + POS_WIDTH'(1);
  assign nxt_ext = CMP_W'(nxt_col);
  assign len_ext = CMP_W'(row_length_i);
  // zero row length behaves as one
  assign wrap    = (nxt_col == '0) || (nxt_ext >= len_ext);

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (push_o) begin
      if (wrap) begin
        col_d = '0;
        row_d = cur_row + POS_WIDTH'(1);
      end else begin
        col_d = nxt_col;
        row_d = cur_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign row_wide = WORD_W'(cur_row);
  assign col_wide = WORD_W'(cur_col);

  always_comb begin
    push_data_o.value    = cell_value_i;
    push_data_o.is_null  = cell_is_null_i;
    push_data_o.eligible = null_pick_en_i || !cell_is_null_i;
    push_data_o.rnd      = random_word_i;
    push_data_o.first    = first_cell_i;
    push_data_o.row      = row_wide[OPOS_W-1:0];
    push_data_o.col      = col_wide[OPOS_W-1:0];
  end

endmodule
`default_nettype wire

@@ rtl/rrcs_fifo.sv @@
// Short queue of classified cell words between front and back end.
// Depends on rrcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrcs_fifo (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  rrcs_pkg::cell_t    push_data_i,
  input  wire                pop_i,
  output rrcs_pkg::cell_t    pop_data_o,
  output rrcs_pkg::q_stat_t  stat_o
);
  import rrcs_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  cell_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + PTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PTR_W'(1) : rd_q;
    cnt_d = cnt_q + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/rrcs_back.sv @@
// Back end: sampling counters, serial modulo unit and output register.
// Depends on rrcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrcs_back #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  rrcs_pkg::cfg_t     cfg_i,
  input  rrcs_pkg::q_stat_t  q_stat_i,
  input  rrcs_pkg::cell_t    q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output rrcs_pkg::res_t     out_data_o
);
  import rrcs_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_WB   = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    ACT_PASS  = 2'd0,
    ACT_SHORT = 2'd1,
    ACT_DRAW  = 2'd2
  } act_e;

  state_e            state_q, state_d;
  act_e              act_q, act_d;
  cell_t             item_q, item_d;
  logic [CW-1:0]     elig_q, elig_d, picks_q, picks_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic [RND_W-1:0]  dvd_q, dvd_d;
  logic [STEP_W-1:0] step_q, step_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [VALUE_W-1:0] total_w, nulls_w, sample_w, picks_w;
  logic [CW-1:0]      total_c, nulls_c, load_elig, elig_eff, picks_eff, picks_new;
  logic [CW:0]        sh, diff;
  logic               ge, out_free, sel;

  assign total_w  = VALUE_W'(cfg_i.total_cells);
  assign nulls_w  = VALUE_W'(cfg_i.null_cells);
  assign sample_w = VALUE_W'(cfg_i.sample_count);
  assign total_c  = total_w[CW-1:0];
  assign nulls_c  = nulls_w[CW-1:0];

  always_comb begin
    if (cfg_i.null_pick_en) begin
      load_elig = total_c;
    end else if (total_c > nulls_c) begin
      load_elig = total_c - nulls_c;
    end else begin
      load_elig = '0;
    end
  end

  assign elig_eff  = q_data_i.first ? load_elig : elig_q;
  assign picks_eff = q_data_i.first ? sample_w[CW-1:0] : picks_q;

  // one restoring step of random_word mod eligible_left
  assign sh   = {rem_q, dvd_q[RND_W-1]};
  assign diff = sh - {1'b0, elig_q};
  assign ge   = (sh >= {1'b0, elig_q});

  assign out_free  = !out_valid_q || !out_stall_i;
  assign sel       = (act_q == ACT_DRAW) && (rem_q < picks_q);
  assign picks_new = picks_q - CW'(sel);
  assign picks_w   = VALUE_W'(picks_new);

  assign pop_o = (state_q == ST_IDLE) && !q_stat_i.empty;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    item_d      = item_q;
    elig_d      = elig_q;
    picks_d     = picks_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    step_d      = step_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          item_d  = q_data_i;
          elig_d  = elig_eff;
          picks_d = picks_eff;
          rem_d   = '0;
          dvd_d   = q_data_i.rnd;
          step_d  = '0;
          if (picks_eff != '0 && q_data_i.eligible) begin
            if (elig_eff == '0) begin
              act_d   = ACT_SHORT;
              state_d = ST_WB;
            end else begin
              act_d   = ACT_DRAW;
              state_d = ST_DIV;
            end
          end else begin
            act_d   = ACT_PASS;
            state_d = ST_WB;
          end
        end
      end
      ST_DIV: begin
        rem_d  = ge ? diff[CW-1:0] : sh[CW-1:0];
        dvd_d  = {dvd_q[RND_W-2:0], 1'b0};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(RND_W - 1)) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        if (out_free) begin
          if (act_q == ACT_DRAW) begin
            elig_d  = elig_q - CW'(1);
            picks_d = picks_new;
          end
          out_d.value     = sel ? (item_q.is_null ? cfg_i.null_fill_value : item_q.value)
                                : '0;
          out_d.is_null   = !sel;
          out_d.selected  = sel;
          out_d.row       = item_q.row;
          out_d.col       = item_q.col;
          out_d.picks     = picks_w[WORD_W-1:0];
          out_d.shortfall = (act_q == ACT_SHORT);
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      act_q       <= ACT_PASS;
      elig_q      <= '0;
      picks_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      elig_q      <= elig_d;
      picks_q     <= picks_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ rtl/raster_random_cell_sampler_unit.sv @@
// Raster random cell sampler: top level with configuration registers.
// Depends on rrcs_pkg, rrcs_front, rrcs_fifo, rrcs_back and the assert header.
//
// Takes raster cells in row-major order and picks up to sample_count of them
// uniformly by selection sampling; one result word leaves per cell, with its row
// and column. Assert first_cell on the first cell of a window to reload the
// counters from the registers, which the user must write only while the block is
// idle; the block itself does not enforce this. A cell that needs a random draw
// is taken from the queue, runs 32 steps of the bit-serial modulo by
// eligible_left and is written back; other cells skip it. The serial modulo
// unit sets the rate. A two-word queue takes cells while the back end is busy.
`timescale 1ns / 1ps
`default_nettype none
`include "raster_random_cell_sampler_unit_assert.svh"
module raster_random_cell_sampler_unit #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned POS_WIDTH   = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [rrcs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire  [rrcs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  [rrcs_pkg::VALUE_W-1:0]       cell_value_i,
  input  wire                                cell_is_null_i,
  input  wire  [rrcs_pkg::RND_W-1:0]         random_word_i,
  input  wire                                first_cell_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [rrcs_pkg::VALUE_W-1:0]       out_value_o,
  output logic                               out_is_null_o,
  output logic                               selected_o,
  output logic [rrcs_pkg::OPOS_W-1:0]        row_index_o,
  output logic [rrcs_pkg::OPOS_W-1:0]        col_index_o,
  output logic [rrcs_pkg::WORD_W-1:0]        picks_remaining_o,
  output logic                               shortfall_o
);
  import rrcs_pkg::*;

  cfg_t    cfg_q, cfg_d;
  q_stat_t q_stat;
  cell_t   push_data, pop_data;
  res_t    res;
  logic    push, pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_NULL_PICK_EN: cfg_d.null_pick_en    = cfg_data_i[0];
        REG_TOTAL_CELLS:  cfg_d.total_cells     = cfg_data_i[WORD_W-1:0];
        REG_NULL_CELLS:   cfg_d.null_cells      = cfg_data_i[WORD_W-1:0];
        REG_SAMPLE_COUNT: cfg_d.sample_count    = cfg_data_i[WORD_W-1:0];
        REG_NULL_FILL:    cfg_d.null_fill_value = cfg_data_i[VALUE_W-1:0];
        REG_ROW_LENGTH:   cfg_d.row_length      = cfg_data_i[RLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.null_pick_en    <= 1'b0;
      cfg_q.total_cells     <= '0;
      cfg_q.null_cells      <= '0;
      cfg_q.sample_count    <= '0;
      cfg_q.null_fill_value <= '0;
      cfg_q.row_length      <= RLEN_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rrcs_front #(
    .POS_WIDTH(POS_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cell_value_i  (cell_value_i),
    .cell_is_null_i(cell_is_null_i),
    .random_word_i (random_word_i),
    .first_cell_i  (first_cell_i),
    .null_pick_en_i(cfg_q.null_pick_en),
    .row_length_i  (cfg_q.row_length),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  rrcs_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .stat_o     (q_stat)
  );

  rrcs_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_stat_i   (q_stat),
    .q_data_i   (pop_data),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (res)
  );

  assign out_value_o       = res.value;
  assign out_is_null_o     = res.is_null;
  assign selected_o        = res.selected;
  assign row_index_o       = res.row;
  assign col_index_o       = res.col;
  assign picks_remaining_o = res.picks;
  assign shortfall_o       = res.shortfall;

  `RRCS_ASSERT(a_sel_not_null, out_valid_o && selected_o |-> !out_is_null_o)
  `RRCS_ASSERT(a_short_unpicked, out_valid_o && shortfall_o |-> !selected_o && out_is_null_o)
  `RRCS_ASSERT(a_null_zero, out_valid_o && out_is_null_o |-> out_value_o == '0)
  `RRCS_ASSERT(a_queue_sane, !(q_stat.full && q_stat.empty))

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for raster_random_cell_sampler_unit.
// Drives raster windows through the valid/stall ports, predicts every result word
// in-line and compares field by field. Depends on rrcs_pkg and the RTL only.
`timescale 1ns / 1ps
module tb_top;
  import rrcs_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 500000;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [VALUE_W-1:0] cell_value_i = '0;
  logic cell_is_null_i = 1'b0;
  logic [RND_W-1:0] random_word_i = '0;
  logic first_cell_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [VALUE_W-1:0] out_value_o;
  logic out_is_null_o;
  logic selected_o;
  logic [OPOS_W-1:0] row_index_o;
  logic [OPOS_W-1:0] col_index_o;
  logic [WORD_W-1:0] picks_remaining_o;
  logic shortfall_o;

  raster_random_cell_sampler_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .cell_value_i(cell_value_i),
    .cell_is_null_i(cell_is_null_i),
    .random_word_i(random_word_i),
    .first_cell_i(first_cell_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_value_o(out_value_o),
    .out_is_null_o(out_is_null_o),
    .selected_o(selected_o),
    .row_index_o(row_index_o),
    .col_index_o(col_index_o),
    .picks_remaining_o(picks_remaining_o),
    .shortfall_o(shortfall_o)
  );

  // Register mirror and sampler state
  cfg_t cfg_mirror;
  logic [WORD_W-1:0] elig_left;
  logic [WORD_W-1:0] picks_left;
  logic [OPOS_W-1:0] row_pos;
  logic [OPOS_W-1:0] col_pos;

  res_t pending_results[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic [7:0] hold_seq = '0;
  logic [7:0] hold_seen = '0;
  int unsigned hold_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic res_t sample_cell(logic [VALUE_W-1:0] value, logic is_null,
                                       logic [RND_W-1:0] rnd, logic first);
    res_t r;
    logic [OPOS_W-1:0] next_col;
    if (first) begin
      picks_left = cfg_mirror.sample_count;
      if (cfg_mirror.null_pick_en) begin
        elig_left = cfg_mirror.total_cells;
      end else begin
        elig_left = (cfg_mirror.total_cells > cfg_mirror.null_cells) ?
                    cfg_mirror.total_cells - cfg_mirror.null_cells : '0;
      end
      row_pos = '0;
      col_pos = '0;
    end
    r = '0;
    r.is_null = 1'b1;
    r.row = row_pos;
    r.col = col_pos;
    if (picks_left != 0 && (cfg_mirror.null_pick_en || !is_null)) begin
      if (elig_left == 0) begin
        r.shortfall = 1'b1;
      end else begin
        if ((rnd % elig_left) < picks_left) begin
          picks_left = picks_left - 1'b1;
          r.selected = 1'b1;
          r.is_null = 1'b0;
          r.value = is_null ? cfg_mirror.null_fill_value : value;
        end
        elig_left = elig_left - 1'b1;
      end
    end
    // row_length of zero behaves as one
    next_col = col_pos + 1'b1;
    if (next_col == 0 || next_col >= cfg_mirror.row_length) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = next_col;
    end
    r.picks = picks_left;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none got value %h null %b sel %b",
                 $time, out_value_o, out_is_null_o, selected_o);
      end else begin
        want = pending_results.pop_front();
        check_field("out_value", want.value, out_value_o);
        check_field("out_is_null", want.is_null, out_is_null_o);
        check_field("selected", want.selected, selected_o);
        check_field("row_index", want.row, row_index_o);
        check_field("col_index", want.col, col_index_o);
        check_field("picks_remaining", want.picks, picks_remaining_o);
        check_field("shortfall", want.shortfall, shortfall_o);
      end
    end
  end

  // Receiver: random stall, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_cell(logic [VALUE_W-1:0] value, logic is_null,
                           logic [RND_W-1:0] rnd, logic first);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cell_value_i <= value;
    cell_is_null_i <= is_null;
    random_word_i <= rnd;
    first_cell_i <= first;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(sample_cell(value, is_null, rnd, first));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_NULL_PICK_EN: cfg_mirror.null_pick_en = data[0];
      REG_TOTAL_CELLS: cfg_mirror.total_cells = data[WORD_W-1:0];
      REG_NULL_CELLS: cfg_mirror.null_cells = data[WORD_W-1:0];
      REG_SAMPLE_COUNT: cfg_mirror.sample_count = data[WORD_W-1:0];
      REG_NULL_FILL: cfg_mirror.null_fill_value = data;
      REG_ROW_LENGTH: cfg_mirror.row_length = data[RLEN_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(logic use_n, logic [WORD_W-1:0] total, logic [WORD_W-1:0] nulls,
                            logic [WORD_W-1:0] picks, logic [VALUE_W-1:0] fill,
                            logic [RLEN_W-1:0] rlen);
    wait_idle();
    write_reg(REG_NULL_PICK_EN, use_n);
    write_reg(REG_TOTAL_CELLS, total);
    write_reg(REG_NULL_CELLS, nulls);
    write_reg(REG_SAMPLE_COUNT, picks);
    write_reg(REG_NULL_FILL, fill);
    write_reg(REG_ROW_LENGTH, rlen);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    // counters are zero out of reset: nothing can be picked
    send_cell('1, 1'b0, '1, 1'b0);
    // skipped null, picks at both random extremes, then quota met
    set_config(1'b0, 4, 1, 2, '1, 2);
    send_cell('1, 1'b0, '1, 1'b1);
    send_cell({$urandom, $urandom}, 1'b1, '0, 1'b0);
    send_cell('0, 1'b0, '0, 1'b0);
    send_cell(64'h0123_4567_89ab_cdef, 1'b0, 32'h8000_0000, 1'b0);
    send_cell({$urandom, $urandom}, 1'b0, $urandom, 1'b0);
    // more nulls than cells: eligible saturates at zero, all short
    set_config(1'b0, 2, 5, 3, '0, 1);
    for (int i = 0; i < 3; i++) send_cell({$urandom, $urandom}, 1'b0, $urandom, i == 0);
    // eligible runs out while picks remain
    set_config(1'b0, 1, 0, 2, '0, 1);
    send_cell({$urandom, $urandom}, 1'b0, $urandom, 1'b1);
    send_cell({$urandom, $urandom}, 1'b0, $urandom, 1'b0);
    // null candidates take the fill value
    set_config(1'b1, 3, 3, 3, {$urandom, $urandom}, 3);
    for (int i = 0; i < 4; i++) send_cell({$urandom, $urandom}, 1'b1, $urandom, i == 0);
    // widest counts, zero row length
    set_config(1'b1, '1, '1, '1, '1, 0);
    send_cell('1, 1'b1, '1, 1'b1);
    send_cell('0, 1'b0, '0, 1'b0);
    send_cell({$urandom, $urandom}, 1'b0, '1, 1'b0);
    // nothing to pick, longest row
    set_config(1'b0, 2, 0, 0, {$urandom, $urandom}, '1);
    send_cell({$urandom, $urandom}, 1'b0, $urandom, 1'b1);
    send_cell({$urandom, $urandom}, 1'b0, $urandom, 1'b0);
  endtask

  task automatic send_window(int unsigned cells, int unsigned nulls, logic broken);
    int unsigned left_cells;
    int unsigned left_nulls;
    int unsigned stop;
    logic is_null;
    left_cells = cells;
    left_nulls = nulls;
    stop = broken ? $urandom_range(1, cells + 3) : cells;
    for (int unsigned i = 0; i < stop; i++) begin
      if (left_cells != 0) begin
        is_null = ($urandom_range(1, left_cells) <= left_nulls);
        left_nulls -= is_null;
        left_cells--;
      end else begin
        is_null = $urandom_range(0, 1);
      end
      send_cell({$urandom, $urandom}, is_null, $urandom,
                i == 0 || (broken && $urandom_range(0, 15) == 0));
    end
  endtask

  task automatic test_random_windows(int unsigned n_items);
    int unsigned start;
    int unsigned cells;
    int unsigned nulls;
    int unsigned elig;
    int unsigned kind;
    int unsigned picks;
    int unsigned rsel;
    logic use_n;
    logic [RLEN_W-1:0] rlen;
    start = n_sent;
    while (n_sent - start < n_items) begin
      // kind 0: null count misstated, 1: quota beyond eligible, 2: broken windows
      kind = $urandom_range(0, 9);
      cells = $urandom_range(1, 24);
      nulls = $urandom_range(0, cells);
      use_n = $urandom_range(0, 1);
      elig = use_n ? cells : cells - nulls;
      picks = (kind == 1) ? $urandom_range(elig + 1, elig + 4) : $urandom_range(0, elig);
      rsel = $urandom_range(0, 9);
      rlen = (rsel == 0) ? '0 : (rsel == 1) ? '1 : RLEN_W'($urandom_range(1, 6));
      set_config(use_n, cells, (kind == 0) ? $urandom_range(0, cells + 3) : nulls, picks,
                 {$urandom, $urandom}, rlen);
      repeat ($urandom_range(1, 3)) send_window(cells, nulls, kind == 2);
    end
  endtask

  task automatic test_holdoff();
    set_config(1'b1, 12, 0, 6, {$urandom, $urandom}, 4);
    hold_seq <= hold_seq + 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_cell({$urandom, $urandom}, $urandom_range(0, 1), $urandom, i == 0);
    end
    // sender waits for every word before going on
    wait_idle();
  endtask

  initial begin
    cfg_mirror = '0;
    cfg_mirror.row_length = 1;
    elig_left = '0;
    picks_left = '0;
    row_pos = '0;
    col_pos = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 19;
    recv_idle_pct = 65;
    test_directed();
    test_random_windows(RANDOM_ITEMS / 3);
    send_idle_pct = 65;
    recv_idle_pct = 19;
    test_random_windows(RANDOM_ITEMS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_holdoff();
    test_random_windows(RANDOM_ITEMS / 3);

    wait_idle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
